// ----- design/bphd_pkg.sv -----
package bphd_pkg;

    localparam int LIMIT_W        = 16;
    localparam int TICK_W         = 8;
    localparam int MODE_W         = 3;
    localparam int CFG_IDX_W      = 2;
    localparam int COUNT_WIDTH_DF = 16;

    localparam logic [LIMIT_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [LIMIT_W-1:0] LONG_RST     = 16'd1000;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG     = 2'd1;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_IDLE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DEBOUNCING = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DOWN       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PRESSED    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HELD       = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HELD_WAIT  = 3'd5;

    typedef struct packed {
        logic              level;
        logic [TICK_W-1:0] elapsed_ticks;
    } t_item;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              short_press;
        logic              long_hold;
    } t_result;

    typedef struct packed {
        logic [LIMIT_W-1:0] debounce_limit;
        logic [LIMIT_W-1:0] long_press_limit;
    } t_limits;

endpackage

// ----- design/bphd_step.sv -----
module bphd_step #(
    parameter int COUNT_WIDTH = bphd_pkg::COUNT_WIDTH_DF
) (
    input  logic [bphd_pkg::MODE_W-1:0] i_mode,
    input  logic [COUNT_WIDTH-1:0]      i_total,
    input  bphd_pkg::t_item             i_item,
    input  bphd_pkg::t_limits           i_limits,
    output logic [bphd_pkg::MODE_W-1:0] o_mode,
    output logic [COUNT_WIDTH-1:0]      o_total
);
    import bphd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [COUNT_WIDTH:0]   sum;
    logic [COUNT_WIDTH-1:0] acc;
    logic [CMP_W-1:0]       acc_cmp;
    logic [CMP_W-1:0]       deb_cmp;
    logic [CMP_W-1:0]       long_cmp;

    // saturating accumulate
    assign sum      = {1'b0, i_total} + {{(COUNT_WIDTH+1-TICK_W){1'b0}}, i_item.elapsed_ticks};
    assign acc      = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];
    assign acc_cmp  = CMP_W'(acc);
    assign deb_cmp  = CMP_W'(i_limits.debounce_limit);
    assign long_cmp = CMP_W'(i_limits.long_press_limit);

    always_comb begin
        o_mode  = i_mode;
        o_total = i_total;
        unique case (i_mode)
            MODE_IDLE: begin
                if (i_item.level) begin
                    o_mode = MODE_DEBOUNCING;
                end
            end
            MODE_DEBOUNCING: begin
                if (!i_item.level) begin
                    o_mode  = MODE_IDLE;
                    o_total = '0;
                end else begin
                    o_total = acc;
                    if (acc_cmp >= deb_cmp) begin
                        o_mode = MODE_DOWN;
                    end
                end
            end
            MODE_DOWN: begin
                if (!i_item.level) begin
                    o_mode = MODE_PRESSED;
                end else if (acc_cmp >= long_cmp) begin
                    o_mode  = MODE_HELD;
                    o_total = '0;
                end else begin
                    o_total = acc;
                end
            end
            MODE_PRESSED: begin
                o_mode  = MODE_IDLE;
                o_total = '0;
            end
            MODE_HELD: begin
                o_mode = MODE_HELD_WAIT;
            end
            MODE_HELD_WAIT: begin
                if (!i_item.level) begin
                    o_mode  = MODE_IDLE;
                    o_total = '0;
                end
            end
            default: begin
                o_mode  = MODE_IDLE;
                o_total = '0;
            end
        endcase
    end

endmodule

// ----- design/button_press_hold_detector.sv -----
// button press and long-hold detector
// input channel: i_in_valid / o_in_stall carry one reading (level, elapsed
// ticks); a transaction completes on a clock edge with valid high and stall low
// output channel: o_out_valid / i_out_stall carry one result per reading
// (mode, short_press, long_hold), in the order the readings arrived
// configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// index 0 is the debounce limit, 1 the long-press limit, others are ignored;
// write only while the block is idle
// latency: a reading sits in the input register for one cycle, then the mode
// update and result are registered, so its result shows one cycle after
// acceptance; one reading per cycle is sustained, set by the single-cycle
// add, saturate and compare on the tick accumulator
// when the receiver stalls the result register holds, and once the input
// register also holds a reading o_in_stall rises and stays high until the
// receiver takes the result
// reset (i_rst_n low, synchronous) empties both registers, sets the mode to
// idle, clears the accumulator and loads limits of 20 and 1000 ticks
module button_press_hold_detector #(
    parameter int COUNT_WIDTH = bphd_pkg::COUNT_WIDTH_DF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  bphd_pkg::t_item                i_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output bphd_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bphd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bphd_pkg::LIMIT_W-1:0]   i_cfg_data
);
    import bphd_pkg::*;

    logic                   r_in_valid;
    t_item                  r_item;
    logic                   r_out_valid;
    t_result                r_result;
    logic [MODE_W-1:0]      r_mode;
    logic [COUNT_WIDTH-1:0] r_total;
    t_limits                r_limits;

    logic [MODE_W-1:0]      n_mode;
    logic [COUNT_WIDTH-1:0] n_total;
    logic                   advance;
    logic                   in_take;

    // result register free or being emptied this cycle
    assign advance     = !r_out_valid || !i_out_stall;
    assign in_take     = !r_in_valid || advance;
    assign o_in_stall  = !in_take;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_cfg_ready = 1'b1;

    bphd_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .i_mode  (r_mode),
        .i_total (r_total),
        .i_item  (r_item),
        .i_limits(r_limits),
        .o_mode  (n_mode),
        .o_total (n_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_IDLE;
            r_total     <= '0;
            r_limits.debounce_limit   <= DEBOUNCE_RST;
            r_limits.long_press_limit <= LONG_RST;
        end else begin
            if (in_take) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_mode  <= n_mode;
                    r_total <= n_total;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_DEBOUNCE: r_limits.debounce_limit   <= i_cfg_data;
                    REG_LONG:     r_limits.long_press_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_item <= i_item;
        end
        if (advance && r_in_valid) begin
            r_result.mode        <= n_mode;
            r_result.short_press <= (n_mode == MODE_PRESSED);
            r_result.long_hold   <= (n_mode == MODE_HELD);
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> (r_total == '0))
        else $error("accumulator not clear in idle");

    a_held_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_mode == MODE_HELD) |=> (r_mode == MODE_HELD_WAIT))
        else $error("held mode lasted more than one reading");

    a_pressed_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_valid && r_mode == MODE_PRESSED) |=> (r_mode == MODE_IDLE))
        else $error("pressed mode lasted more than one reading");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_result.short_press == (r_result.mode == MODE_PRESSED)) &&
                         (r_result.long_hold == (r_result.mode == MODE_HELD))))
        else $error("event flags disagree with mode");

endmodule

// ----- dv/tb_button_press_hold_detector.sv -----
module tb_button_press_hold_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import bphd_pkg::*;

    localparam int CNT_W       = COUNT_WIDTH_DF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 12;

    // indexes beyond the two limit registers, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    t_item                i_item      = '0;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [LIMIT_W-1:0]   i_cfg_data  = '0;
    logic                 o_in_stall;
    logic                 o_out_valid;
    t_result              o_result;
    logic                 o_cfg_ready;

    button_press_hold_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_item      (i_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow of the detector state
    logic [MODE_W-1:0] shadow_mode  = MODE_IDLE;
    logic [CNT_W-1:0]  shadow_ticks = '0;
    t_limits           shadow_limits = '{debounce_limit: DEBOUNCE_RST,
                                         long_press_limit: LONG_RST};

    t_item   readings_pending[$];
    t_result modes_expected[$];
    int      readings_queued = 0;
    int      fail_count      = 0;
    int      cycle_count     = 0;

    // stimulus shaping, set from the sequencing block
    int   gap_max        = 0;
    int   stall_pct      = 0;
    logic long_stall_req = 1'b0;

    function automatic t_result step_detector(t_item rd);
        t_result        res;
        logic [CNT_W:0] sum;
        sum = {1'b0, shadow_ticks} + (CNT_W+1)'(rd.elapsed_ticks);
        case (shadow_mode)
            MODE_IDLE: begin
                if (rd.level) shadow_mode = MODE_DEBOUNCING;
            end
            MODE_DEBOUNCING: begin
                if (!rd.level) begin
                    shadow_mode  = MODE_IDLE;
                    shadow_ticks = '0;
                end else begin
                    shadow_ticks = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                    if (shadow_ticks >= shadow_limits.debounce_limit)
                        shadow_mode = MODE_DOWN;
                end
            end
            MODE_DOWN: begin
                if (!rd.level) begin
                    shadow_mode = MODE_PRESSED;
                end else begin
                    shadow_ticks = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
                    if (shadow_ticks >= shadow_limits.long_press_limit) begin
                        shadow_mode  = MODE_HELD;
                        shadow_ticks = '0;
                    end
                end
            end
            MODE_PRESSED: begin
                shadow_mode  = MODE_IDLE;
                shadow_ticks = '0;
            end
            MODE_HELD: begin
                shadow_mode = MODE_HELD_WAIT;
            end
            MODE_HELD_WAIT: begin
                if (!rd.level) begin
                    shadow_mode  = MODE_IDLE;
                    shadow_ticks = '0;
                end
            end
            default: begin
                shadow_mode  = MODE_IDLE;
                shadow_ticks = '0;
            end
        endcase
        res.mode        = shadow_mode;
        res.short_press = (shadow_mode == MODE_PRESSED);
        res.long_hold   = (shadow_mode == MODE_HELD);
        return res;
    endfunction

    task automatic log_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endtask

    // sender: bursts of transactions separated by random gaps
    int gap_left   = 0;
    int burst_left = 0;

    always @(posedge i_clk) begin
        logic holding;
        holding = i_in_valid && o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                modes_expected.push_back(step_detector(readings_pending.pop_front()));
            if (!holding) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (readings_pending.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_item     <= readings_pending[0];
                    if (burst_left == 0) burst_left = $urandom_range(1, 24);
                    burst_left--;
                    if (burst_left == 0 && gap_max != 0)
                        gap_left = $urandom_range(0, gap_max);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks results and stalls in runs, plus long hold-offs on request
    int   stall_run_left  = 0;
    logic stall_run_state = 1'b0;
    int   long_stall_left = 0;
    logic long_stall_seen = 1'b0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (modes_expected.size() == 0) begin
                    log_failure($sformatf("result with nothing expected: mode %0d sp %0b lh %0b",
                                          o_result.mode, o_result.short_press,
                                          o_result.long_hold));
                end else begin
                    want = modes_expected.pop_front();
                    if (o_result.mode !== want.mode ||
                        o_result.short_press !== want.short_press ||
                        o_result.long_hold !== want.long_hold)
                        log_failure($sformatf({"expected mode %0d sp %0b lh %0b, ",
                                               "got mode %0d sp %0b lh %0b"},
                                              want.mode, want.short_press, want.long_hold,
                                              o_result.mode, o_result.short_press,
                                              o_result.long_hold));
                end
            end
            if (long_stall_req != long_stall_seen) begin
                long_stall_seen = long_stall_req;
                long_stall_left = 250;
            end
            if (long_stall_left != 0) begin
                long_stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (stall_run_left == 0) begin
                    stall_run_state = ($urandom_range(0, 99) < stall_pct);
                    stall_run_left  = $urandom_range(1, 8);
                end
                stall_run_left--;
                i_out_stall <= stall_run_state;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_reading(logic lv, logic [TICK_W-1:0] tk);
        readings_pending.push_back(t_item'{level: lv, elapsed_ticks: tk});
        readings_queued++;
    endtask

    function automatic logic [TICK_W-1:0] pick_ticks(int pct_max);
        if ($urandom_range(0, 99) < pct_max) return '1;
        if ($urandom_range(0, 3) == 0) return TICK_W'($urandom_range(0, 3));
        return TICK_W'($urandom_range(0, 255));
    endfunction

    // mostly clean press / release sequences, some random chatter
    task automatic gen_presses(int n, int short_max, int long_lo, int long_hi, int pct_max);
        int stop_at;
        int kind;
        int len;
        stop_at = readings_queued + n;
        while (readings_queued < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                len = $urandom_range(1, 3);
                repeat (len) add_reading(1'b0, pick_ticks(pct_max));
                len = (kind < 3) ? $urandom_range(1, short_max)
                                 : $urandom_range(long_lo, long_hi);
                repeat (len) add_reading(1'b1, pick_ticks(pct_max));
                len = $urandom_range(1, 3);
                repeat (len) add_reading(1'b0, pick_ticks(pct_max));
            end else begin
                len = $urandom_range(1, 8);
                repeat (len) add_reading(1'($urandom_range(0, 1)), pick_ticks(pct_max));
            end
        end
    endtask

    // wait until every transaction is through and the block has settled
    task automatic drain();
        while (readings_pending.size() != 0 || i_in_valid || modes_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIMIT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_DEBOUNCE)
            shadow_limits.debounce_limit = data;
        else if (idx == REG_LONG)
            shadow_limits.long_press_limit = data;
    endtask

    task automatic set_limits(logic [LIMIT_W-1:0] deb, logic [LIMIT_W-1:0] lng);
        drain();
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_LONG, lng);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed walk through every mode with the reset limits
        gap_max   <= 2;
        stall_pct <= 20;
        add_reading(1'b0, 8'd255);
        add_reading(1'b1, 8'd0);
        add_reading(1'b1, 8'd0);
        add_reading(1'b1, 8'd19);
        add_reading(1'b0, 8'd200);   // release while debouncing
        add_reading(1'b1, 8'd7);
        add_reading(1'b1, 8'd20);    // exactly at the debounce limit
        add_reading(1'b1, 8'd255);
        add_reading(1'b0, 8'd0);     // short press
        add_reading(1'b1, 8'd255);   // pressed goes idle whatever the level
        add_reading(1'b1, 8'd255);
        add_reading(1'b1, 8'd255);
        add_reading(1'b1, 8'd255);
        add_reading(1'b1, 8'd255);
        add_reading(1'b1, 8'd255);   // long hold
        add_reading(1'b1, 8'd255);
        add_reading(1'b1, 8'd255);   // still held down while waiting
        add_reading(1'b0, 8'd9);
        add_reading(1'b1, 8'd0);
        add_reading(1'b1, 8'd255);
        add_reading(1'b1, 8'd255);
        add_reading(1'b1, 8'd255);
        add_reading(1'b1, 8'd255);   // long hold, released straight after
        add_reading(1'b0, 8'd128);
        add_reading(1'b0, 8'd0);

        // reset limits, with a long receiver hold-off while the sender keeps going
        drain();
        gap_max   <= 0;
        stall_pct <= 30;
        gen_presses(130, 6, 4, 40, 10);
        long_stall_req <= ~long_stall_req;
        drain();

        // limits of one tick each
        set_limits(16'd1, 16'd1);
        gap_max   <= 0;
        stall_pct <= 50;
        gen_presses(100, 3, 1, 6, 0);

        // zero limits, and writes to unused indexes that must be dropped
        set_limits(16'd0, 16'd0);
        write_reg(REG_SPARE_A, 16'hFFFF);
        write_reg(REG_SPARE_B, 16'(  $urandom_range(0, 65535)));
        gap_max   <= 2;
        stall_pct <= 0;
        gen_presses(70, 3, 1, 5, 0);

        // largest limits, long holds push the accumulator into saturation
        set_limits(16'hFFFF, 16'hFFFF);
        gap_max   <= 0;
        stall_pct <= 20;
        gen_presses(330, 4, 280, 330, 95);

        set_limits(16'($urandom_range(1, 300)), 16'($urandom_range(1, 3000)));
        gap_max   <= 8;
        stall_pct <= 60;
        gen_presses(160, 6, 4, 40, 20);
        long_stall_req <= ~long_stall_req;

        set_limits(16'd300, 16'hFFFF);
        gap_max   <= 1;
        stall_pct <= 10;
        gen_presses(90, 6, 250, 300, 95);

        // debounce saturates past a small long-press limit
        set_limits(16'hFFFF, 16'd100);
        gap_max   <= 3;
        stall_pct <= 35;
        gen_presses(90, 4, 270, 300, 95);

        set_limits(16'($urandom_range(1, 50)), 16'($urandom_range(1, 400)));
        gap_max   <= 3;
        stall_pct <= 40;
        gen_presses(70, 6, 2, 20, 0);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
